// ===== rtl/i2cws_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cws_pkg
// Shared types and constants of the I2C master write sequencer.
// ----------------------------------------------------------------------------
package i2cws_pkg;

  localparam int unsigned WaitW      = 16;
  localparam logic [WaitW-1:0] WaitTicksReset = 16'd400;
  localparam int unsigned ByteW      = 8;
  localparam logic [3:0]  AckBit     = 4'd8;
  localparam logic [1:0]  LastPhase  = 2'd2;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    action_t          kind;
    logic [ByteW-1:0] data;
  } cmd_t;

  // Front-to-back command channel
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

endpackage

// ===== rtl/i2c_master_write_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_write_sequencer_top
// Write-only I2C master sequencer: turns start, byte-write and stop commands
// into ordered open-drain SCL/SDA line states (1 = released).
// ----------------------------------------------------------------------------
//
//  channel  | ports                                    | beat moves when
//  ---------+------------------------------------------+----------------------
//  input    | in_push in_full in_action in_data_byte   | in_push  & !in_full
//  result   | out_pop out_empty out_scl_line ...       | out_pop  & !out_empty
//  config   | cfg_wr_en cfg_wr_data (wait_ticks)       | cfg_wr_en
//
//  A start yields 3 line states (2 held one wait period), a stop 3 (all held),
//  a byte write 27 (19 held). One state per cycle at most; a held state delays
//  the next by one wait period. Loading a command overlaps the hold of the
//  previous final state and adds delay only at a wait period of zero; an idle
//  sequencer shows the first state after the queue write, the load and the
//  output register. A result not popped stalls the sequencer. Reset is
//  synchronous, active low, and empties the queue and the result register.
//  Until full, the two-entry command queue keeps accepting beats while the
//  sequencer is busy or the result stalled; action 3 is accepted and dropped.
//
module i2c_master_write_sequencer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // command input
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [1:0]                  in_action,
  input  logic [i2cws_pkg::ByteW-1:0] in_data_byte,
  // line state results
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_scl_line,
  output logic                        out_sda_line,
  output logic                        out_hold_waits,
  output logic                        out_last,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [i2cws_pkg::WaitW-1:0] cfg_wr_data
);

  i2cws_pkg::cmd_chan_t        cmd_chan;
  logic                        cmd_pop;
  logic [i2cws_pkg::WaitW-1:0] wait_ticks_r;

  // Hold the wait period register; it sets pacing only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks_r <= i2cws_pkg::WaitTicksReset;
    end else if (cfg_wr_en) begin
      wait_ticks_r <= cfg_wr_data;
    end
  end

  // Front: accept and classify commands, queue them
  i2cws_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .cmd_chan     (cmd_chan),
    .cmd_pop      (cmd_pop)
  );

  // Back: expand each command into line states
  i2cws_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_chan       (cmd_chan),
    .cmd_pop        (cmd_pop),
    .wait_ticks     (wait_ticks_r),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_scl_line   (out_scl_line),
    .out_sda_line   (out_sda_line),
    .out_hold_waits (out_hold_waits),
    .out_last       (out_last)
  );

endmodule

// ===== rtl/i2cws_front.sv =====
// ----------------------------------------------------------------------------
// i2cws_front
// Accepts commands, drops the unused action code, and queues the rest
// in a two-entry command queue toward the line sequencer.
// ----------------------------------------------------------------------------
module i2cws_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_action,
  input  logic [i2cws_pkg::ByteW-1:0] in_data_byte,
  output i2cws_pkg::cmd_chan_t       cmd_chan,
  input  logic                       cmd_pop
);

  i2cws_pkg::cmd_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            accept;
  logic            enq;
  logic            deq;
  i2cws_pkg::cmd_t cmd_in;

  assign in_full = (count_r == 2'd2);
  assign accept  = in_push && !in_full;

  always_comb begin
    cmd_in.kind = i2cws_pkg::action_t'(in_action);
    cmd_in.data = in_data_byte;
  end

  // Drop the unused code at the door: it causes no line state.
  assign enq = accept && (cmd_in.kind != i2cws_pkg::ACT_NONE);
  assign deq = cmd_pop && (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ enq;
    rd_ptr_nxt = rd_ptr_r ^ deq;
    count_nxt  = count_r + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_comb begin
    cmd_chan.valid = (count_r != 2'd0);
    cmd_chan.cmd   = mem_r[rd_ptr_r];
  end

endmodule

// ===== rtl/i2cws_back.sv =====
// ----------------------------------------------------------------------------
// i2cws_back
// Line sequencer: expands one command into SCL/SDA line states, one state
// per step, paced by the wait period, into a one-entry output register.
// ----------------------------------------------------------------------------
module i2cws_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  i2cws_pkg::cmd_chan_t        cmd_chan,
  output logic                        cmd_pop,
  input  logic [i2cws_pkg::WaitW-1:0] wait_ticks,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_scl_line,
  output logic                        out_sda_line,
  output logic                        out_hold_waits,
  output logic                        out_last
);

  i2cws_pkg::back_state_t state_r, state_nxt;
  i2cws_pkg::action_t     kind_r;
  logic [i2cws_pkg::ByteW-1:0] shift_r;
  logic [3:0]             bit_cnt_r;
  logic [1:0]             phase_r;
  logic                   scl_lvl_r;
  logic [i2cws_pkg::WaitW-1:0] wait_cnt_r;
  logic                   out_valid_r;
  logic                   scl_r, sda_r, hold_r, last_r;

  logic step;
  logic load;
  logic g_scl, g_sda, g_hold, g_last;
  logic is_ack;
  logic bit_val;

  assign is_ack  = (bit_cnt_r == i2cws_pkg::AckBit);
  assign bit_val = is_ack ? 1'b1 : shift_r[i2cws_pkg::ByteW-1];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i2cws_pkg::BK_IDLE: if (cmd_chan.valid) state_nxt = i2cws_pkg::BK_RUN;
      i2cws_pkg::BK_RUN:  if (step && g_last) state_nxt = i2cws_pkg::BK_IDLE;
      default:            state_nxt = i2cws_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the control
  always_comb begin
    load = 1'b0;
    step = 1'b0;
    case (state_r)
      i2cws_pkg::BK_IDLE: load = cmd_chan.valid;
      i2cws_pkg::BK_RUN:  step = (wait_cnt_r == '0) && (!out_valid_r || out_pop);
      default: begin
        load = 1'b0;
        step = 1'b0;
      end
    endcase
  end

  assign cmd_pop = load;

  // Line state for the current phase
  always_comb begin
    g_scl  = 1'b1;
    g_sda  = 1'b1;
    g_hold = 1'b1;
    g_last = 1'b0;
    case (kind_r)
      i2cws_pkg::ACT_START: begin
        case (phase_r)
          2'd0:    begin g_scl = 1'b1; g_sda = 1'b1; g_hold = 1'b0; end
          2'd1:    begin g_scl = 1'b1; g_sda = 1'b0; end
          default: begin g_scl = 1'b0; g_sda = 1'b0; g_last = 1'b1; end
        endcase
      end
      i2cws_pkg::ACT_STOP: begin
        case (phase_r)
          2'd0:    begin g_scl = scl_lvl_r; g_sda = 1'b0; end
          2'd1:    begin g_scl = 1'b1; g_sda = 1'b0; end
          default: begin g_scl = 1'b1; g_sda = 1'b1; g_last = 1'b1; end
        endcase
      end
      default: begin
        g_sda = bit_val;
        case (phase_r)
          2'd0:    g_scl = scl_lvl_r;
          2'd1:    g_scl = 1'b1;
          default: begin
            g_scl  = 1'b0;
            g_hold = is_ack;
            g_last = is_ack;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2cws_pkg::BK_IDLE;
      scl_lvl_r   <= 1'b1;
      wait_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= 2'd0;
      bit_cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      if (out_pop && out_valid_r && !step) begin
        out_valid_r <= 1'b0;
      end
      // Count down the hold of the last emitted state
      if (wait_cnt_r != '0) begin
        wait_cnt_r <= wait_cnt_r - {{(i2cws_pkg::WaitW-1){1'b0}}, 1'b1};
      end
      if (load) begin
        phase_r   <= 2'd0;
        bit_cnt_r <= 4'd0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
        scl_lvl_r   <= g_scl;
        wait_cnt_r  <= g_hold ? wait_ticks : '0;
        if (phase_r == i2cws_pkg::LastPhase) begin
          phase_r   <= 2'd0;
          bit_cnt_r <= bit_cnt_r + 4'd1;
        end else begin
          phase_r <= phase_r + 2'd1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= cmd_chan.cmd.kind;
      shift_r <= cmd_chan.cmd.data;
    end else if (step && (phase_r == i2cws_pkg::LastPhase)) begin
      shift_r <= {shift_r[i2cws_pkg::ByteW-2:0], 1'b0};
    end
    if (step) begin
      scl_r  <= g_scl;
      sda_r  <= g_sda;
      hold_r <= g_hold;
      last_r <= g_last;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_scl_line   = scl_r;
  assign out_sda_line   = sda_r;
  assign out_hold_waits = hold_r;
  assign out_last       = last_r;

endmodule

// ===== bench/i2cws_line_checker.sv =====
// ----------------------------------------------------------------------------
// i2cws_line_checker
// Watches the command, line-state and config channels of the I2C master
// write sequencer, predicts every line state and checks each result beat.
// ----------------------------------------------------------------------------
module i2cws_line_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  logic                        in_full,
  input  logic [1:0]                  in_action,
  input  logic [i2cws_pkg::ByteW-1:0] in_data_byte,
  input  logic                        out_empty,
  input  logic                        out_pop,
  input  logic                        out_scl_line,
  input  logic                        out_sda_line,
  input  logic                        out_hold_waits,
  input  logic                        out_last,
  input  logic                        cfg_wr_en,
  input  logic [i2cws_pkg::WaitW-1:0] cfg_wr_data,
  output int                          mismatches,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic scl;
    logic sda;
    logic hold;
    logic last;
  } line_state_t;

  line_state_t line_q[$];
  logic        scl_lvl;
  int          err_cnt = 0;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("%0t ns: line check: %s", $time, msg);
  endtask

  task automatic put_state(input logic scl, input logic sda, input logic hold,
                           input logic last);
    line_state_t s;
    s.scl   = scl;
    s.sda   = sda;
    s.hold  = hold;
    s.last  = last;
    scl_lvl = scl;
    line_q.push_back(s);
  endtask

  task automatic predict_line_states(input i2cws_pkg::action_t act,
                                     input logic [i2cws_pkg::ByteW-1:0] byte_in);
    logic b;
    case (act)
      i2cws_pkg::ACT_START: begin
        put_state(1'b1, 1'b1, 1'b0, 1'b0);
        put_state(1'b1, 1'b0, 1'b1, 1'b0);
        put_state(1'b0, 1'b0, 1'b1, 1'b1);
      end
      i2cws_pkg::ACT_WRITE: begin
        // MSB first; the first phase of each bit keeps the present clock level
        for (int i = i2cws_pkg::ByteW - 1; i >= 0; i--) begin
          b = byte_in[i];
          put_state(scl_lvl, b, 1'b1, 1'b0);
          put_state(1'b1, b, 1'b1, 1'b0);
          put_state(1'b0, b, 1'b0, 1'b0);
        end
        // ack clock with data released, never sampled
        put_state(scl_lvl, 1'b1, 1'b1, 1'b0);
        put_state(1'b1, 1'b1, 1'b1, 1'b0);
        put_state(1'b0, 1'b1, 1'b1, 1'b1);
      end
      i2cws_pkg::ACT_STOP: begin
        put_state(scl_lvl, 1'b0, 1'b1, 1'b0);
        put_state(1'b1, 1'b0, 1'b1, 1'b0);
        put_state(1'b1, 1'b1, 1'b1, 1'b1);
      end
      default: begin
        // unused code: dropped, state untouched
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %b expected %b", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    line_state_t want;
    if (!rst_n) begin
      line_q.delete();
      scl_lvl = 1'b1;
    end else begin
      // the wait period only paces; flag a write with line states in flight
      if (cfg_wr_en && line_q.size() != 0) begin
        report_mismatch($sformatf("wait period written as %0d with %0d states in flight",
                                  cfg_wr_data, line_q.size()));
      end
      if (out_pop && !out_empty) begin
        if (line_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = line_q.pop_front();
          check_field("scl_line", out_scl_line, want.scl);
          check_field("sda_line", out_sda_line, want.sda);
          check_field("hold_waits", out_hold_waits, want.hold);
          check_field("last", out_last, want.last);
        end
      end
      if (in_push && !in_full) begin
        predict_line_states(i2cws_pkg::action_t'(in_action), in_data_byte);
      end
    end
    pending    <= line_q.size();
    mismatches <= err_cnt;
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives start, byte-write and stop commands into the I2C master write
// sequencer under several wait periods, with random idling on both channels,
// and gives the verdict from the line checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module testbench;
  import i2cws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_push        = 1'b0;
  logic             in_full;
  logic [1:0]       in_action      = ACT_START;
  logic [ByteW-1:0] in_data_byte   = '0;
  logic             out_empty;
  logic             out_pop        = 1'b0;
  logic             out_scl_line;
  logic             out_sda_line;
  logic             out_hold_waits;
  logic             out_last;
  logic             cfg_wr_en      = 1'b0;
  logic [WaitW-1:0] cfg_wr_data    = '0;

  int mismatches;
  int pending;

  // stimulus bookkeeping
  int cur_wait       = 400;
  int cmds_sent      = 0;
  bit tx_idle_en     = 1'b0;
  bit rx_idle_en     = 1'b0;
  bit rx_holdoff_req = 1'b0;

  i2c_master_write_sequencer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_action      (in_action),
    .in_data_byte   (in_data_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_scl_line   (out_scl_line),
    .out_sda_line   (out_sda_line),
    .out_hold_waits (out_hold_waits),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  i2cws_line_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_action      (in_action),
    .in_data_byte   (in_data_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_scl_line   (out_scl_line),
    .out_sda_line   (out_sda_line),
    .out_hold_waits (out_hold_waits),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop. The slowest legal run (both huge wait periods, every result
  // stalled by the longest idle burst) stays well under a tenth of this.
  initial begin
    #60_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Offer one command beat, optionally after an idle burst, and hold it until
  // the queue takes it. Returns right after the accepting edge with push still
  // high, so back-to-back beats never drop push in between.
  task automatic push_cmd(input action_t act, input logic [ByteW-1:0] data);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_action    <= act;
    in_data_byte <= data;
    @(posedge clk);
    while (in_full) @(posedge clk);
    // dropped codes do not count toward the stimulus length
    if (act != ACT_NONE) cmds_sent++;
  endtask

  // Drop push and wait until every predicted line state has been popped, then
  // let the sequencer sit out the hold of its final state before anyone
  // touches the wait period. A wait period of zero may count as a full wrap.
  task automatic drain_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat ((cur_wait == 0 ? 65536 : cur_wait) + 40) @(posedge clk);
  endtask

  // Only called with the block idle; the extra edge keeps each step to one
  // assignment of the write enable.
  task automatic set_wait(input logic [WaitW-1:0] ticks);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
    cur_wait = ticks;
  endtask

  // One random bus transaction. Mostly a clean start / bytes / stop frame with
  // random content, sometimes a broken sequence or a dropped code.
  task automatic send_transaction();
    int kind;
    int nbytes;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      push_cmd(ACT_START, 8'($urandom_range(0, 255)));
      nbytes = $urandom_range(1, 4);
      for (int i = 0; i < nbytes; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          push_cmd(ACT_NONE, 8'($urandom_range(0, 255)));
        end
        push_cmd(ACT_WRITE, 8'($urandom_range(0, 255)));
      end
      // repeated start and one more byte now and then before closing the frame
      if ($urandom_range(0, 5) == 0) begin
        push_cmd(ACT_START, 8'($urandom_range(0, 255)));
        push_cmd(ACT_WRITE, 8'($urandom_range(0, 255)));
      end
      push_cmd(ACT_STOP, 8'($urandom_range(0, 255)));
    end else if (kind == 8) begin
      // commands in any order, no regard for bus state
      nbytes = $urandom_range(1, 3);
      for (int i = 0; i < nbytes; i++) begin
        push_cmd(action_t'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
      end
    end else begin
      push_cmd(ACT_NONE, 8'($urandom_range(0, 255)));
      push_cmd(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: pop every cycle, or idle in bursts, or hold off for a long
  // counted stretch on request so the command queue fills and in_full rises.
  initial begin
    wait (rst_n);
    forever begin
      if (rx_holdoff_req) begin
        out_pop <= 1'b0;
        repeat (400) @(posedge clk);
        rx_holdoff_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int  goal;
    bit  holdoff_done;

    // hold reset, then release it once for good
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset wait period: one short frame, plus a dropped code.
    push_cmd(ACT_START, 8'h00);
    push_cmd(ACT_WRITE, 8'hA5);
    push_cmd(ACT_NONE, 8'h5A);
    push_cmd(ACT_STOP, 8'hFF);
    drain_results();

    // Shortest nonzero wait period: data extremes, single-bit bytes, and commands in odd
    // bus states (stop after stop, byte after stop, start after start).
    set_wait(16'd1);
    push_cmd(ACT_START, 8'hFF);
    push_cmd(ACT_WRITE, 8'h00);
    push_cmd(ACT_WRITE, 8'hFF);
    push_cmd(ACT_WRITE, 8'h80);
    push_cmd(ACT_WRITE, 8'h01);
    push_cmd(ACT_WRITE, 8'h7F);
    push_cmd(ACT_STOP, 8'h00);
    push_cmd(ACT_STOP, 8'hFF);
    push_cmd(ACT_WRITE, 8'h55);
    push_cmd(ACT_NONE, 8'hFF);
    push_cmd(ACT_START, 8'h00);
    push_cmd(ACT_START, 8'hAA);
    push_cmd(ACT_WRITE, 8'hFE);
    push_cmd(ACT_NONE, 8'h00);
    push_cmd(ACT_WRITE, 8'hAA);
    push_cmd(ACT_STOP, 8'h55);
    drain_results();

    // Longest wait period: a start only, a byte would run far too long.
    set_wait(16'hFFFF);
    push_cmd(ACT_START, 8'h3C);
    drain_results();

    // Wait period of zero: stored, line states unchanged.
    set_wait(16'd0);
    push_cmd(ACT_START, 8'hC3);
    drain_results();

    // Random part, first phase: bursty idling on both sides, switched per
    // transaction so clean stretches show up too, and one long receiver
    // hold-off while the sender keeps offering commands.
    set_wait(16'd2);
    goal         = cmds_sent + 110;
    holdoff_done = 1'b0;
    while (cmds_sent < goal) begin
      if (!holdoff_done && cmds_sent >= goal - 60) begin
        rx_holdoff_req = 1'b1;
        holdoff_done   = 1'b1;
      end
      tx_idle_en = ($urandom_range(0, 2) != 0);
      rx_idle_en = ($urandom_range(0, 2) != 0);
      send_transaction();
    end
    // sender pauses here until every line state has come out
    drain_results();

    // second phase at a random short wait period
    set_wait(16'($urandom_range(1, 5)));
    goal = cmds_sent + 110;
    while (cmds_sent < goal) begin
      tx_idle_en = ($urandom_range(0, 2) != 0);
      rx_idle_en = ($urandom_range(0, 2) != 0);
      send_transaction();
    end
    drain_results();

    // last phase: no idling on either side, back to the shortest nonzero wait period
    set_wait(16'd1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    goal = cmds_sent + 100;
    while (cmds_sent < goal) begin
      send_transaction();
    end
    drain_results();

    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== i2c_master_write_sequencer_top.f =====
rtl/i2cws_pkg.sv
rtl/i2cws_front.sv
rtl/i2cws_back.sv
rtl/i2c_master_write_sequencer_top.sv
bench/i2cws_line_checker.sv
bench/testbench.sv
